@@ sv/mmd_pkg.sv @@
// Shared types, constants and the quarter-wave sine table for the mecanum
// move controller. No dependencies; imported by every module of the block.
package mmd_pkg;

  // Defaults for the top-level parameters
  localparam int COUNT_WIDTH_DEF    = 24;
  localparam int TRIG_FRAC_BITS_DEF = 15;

  // Fixed field widths
  localparam int SPEED_W   = 8;
  localparam int HEAD_W    = 9;
  localparam int TURN_W    = 8;
  localparam int DIST_W    = 10;
  localparam int TPC_W     = 16;
  localparam int NUM_W     = TPC_W + DIST_W;
  localparam int DRIVE_W   = 8;
  localparam int TARGET_W  = 32;
  localparam int HDR_W     = SPEED_W + HEAD_W + TURN_W + DIST_W;
  localparam int OUT_W     = 40;
  localparam int NUM_LANES = 4;

  localparam logic [TPC_W-1:0] TICKS_PER_CM_RESET = 16'd9408;
  localparam logic [6:0]       DRIVE_LIMIT        = 7'd100;

  // Angle constants in degrees
  localparam logic [HEAD_W-1:0] DEG_45  = 9'd45;
  localparam logic [HEAD_W-1:0] DEG_90  = 9'd90;
  localparam logic [HEAD_W-1:0] DEG_135 = 9'd135;
  localparam logic [HEAD_W-1:0] DEG_180 = 9'd180;
  localparam logic [HEAD_W-1:0] DEG_270 = 9'd270;
  localparam logic [HEAD_W-1:0] DEG_360 = 9'd360;

  // Item kinds carried on tuser
  localparam logic MODE_START  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // Output bit positions above the four drive bytes
  localparam int OUT_MOVING_BIT = 32;
  localparam int OUT_CLEAR_BIT  = 33;
  localparam int OUT_DONE_BIT   = 34;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      reached;
  } lane_res_t;

  // round(32768 * sin(d)) for d = 0..90
  function automatic logic [15:0] sine_q15(input logic [6:0] d);
    logic [15:0] v;
    case (d)
      7'd0:  v = 16'd0;     7'd1:  v = 16'd572;   7'd2:  v = 16'd1144;
      7'd3:  v = 16'd1715;  7'd4:  v = 16'd2286;  7'd5:  v = 16'd2856;
      7'd6:  v = 16'd3425;  7'd7:  v = 16'd3993;  7'd8:  v = 16'd4560;
      7'd9:  v = 16'd5126;  7'd10: v = 16'd5690;  7'd11: v = 16'd6252;
      7'd12: v = 16'd6813;  7'd13: v = 16'd7371;  7'd14: v = 16'd7927;
      7'd15: v = 16'd8481;  7'd16: v = 16'd9032;  7'd17: v = 16'd9580;
      7'd18: v = 16'd10126; 7'd19: v = 16'd10668; 7'd20: v = 16'd11207;
      7'd21: v = 16'd11743; 7'd22: v = 16'd12275; 7'd23: v = 16'd12803;
      7'd24: v = 16'd13328; 7'd25: v = 16'd13848; 7'd26: v = 16'd14365;
      7'd27: v = 16'd14876; 7'd28: v = 16'd15384; 7'd29: v = 16'd15886;
      7'd30: v = 16'd16384; 7'd31: v = 16'd16877; 7'd32: v = 16'd17364;
      7'd33: v = 16'd17847; 7'd34: v = 16'd18324; 7'd35: v = 16'd18795;
      7'd36: v = 16'd19261; 7'd37: v = 16'd19720; 7'd38: v = 16'd20174;
      7'd39: v = 16'd20622; 7'd40: v = 16'd21063; 7'd41: v = 16'd21498;
      7'd42: v = 16'd21926; 7'd43: v = 16'd22348; 7'd44: v = 16'd22763;
      7'd45: v = 16'd23170; 7'd46: v = 16'd23571; 7'd47: v = 16'd23965;
      7'd48: v = 16'd24351; 7'd49: v = 16'd24730; 7'd50: v = 16'd25102;
      7'd51: v = 16'd25466; 7'd52: v = 16'd25822; 7'd53: v = 16'd26170;
      7'd54: v = 16'd26510; 7'd55: v = 16'd26842; 7'd56: v = 16'd27166;
      7'd57: v = 16'd27482; 7'd58: v = 16'd27789; 7'd59: v = 16'd28088;
      7'd60: v = 16'd28378; 7'd61: v = 16'd28660; 7'd62: v = 16'd28932;
      7'd63: v = 16'd29197; 7'd64: v = 16'd29452; 7'd65: v = 16'd29698;
      7'd66: v = 16'd29935; 7'd67: v = 16'd30163; 7'd68: v = 16'd30382;
      7'd69: v = 16'd30592; 7'd70: v = 16'd30792; 7'd71: v = 16'd30983;
      7'd72: v = 16'd31164; 7'd73: v = 16'd31336; 7'd74: v = 16'd31499;
      7'd75: v = 16'd31651; 7'd76: v = 16'd31795; 7'd77: v = 16'd31928;
      7'd78: v = 16'd32052; 7'd79: v = 16'd32166; 7'd80: v = 16'd32270;
      7'd81: v = 16'd32365; 7'd82: v = 16'd32449; 7'd83: v = 16'd32524;
      7'd84: v = 16'd32588; 7'd85: v = 16'd32643; 7'd86: v = 16'd32688;
      7'd87: v = 16'd32723; 7'd88: v = 16'd32748; 7'd89: v = 16'd32763;
      default: v = 16'd32768;
    endcase
    return v;
  endfunction

endpackage

@@ sv/mmd_trig.sv @@
// Sine lookup for one angle: range reduction, quadrant fold and table read.
// Depends on mmd_pkg for the quarter-wave table and angle constants.
module mmd_trig #(
  parameter int TRIG_FRAC_BITS = mmd_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic [mmd_pkg::HEAD_W-1:0]     angle_i,
  output logic [TRIG_FRAC_BITS:0]        mag_o,
  output logic signed [TRIG_FRAC_BITS+1:0] val_o
);
  import mmd_pkg::*;

  logic [HEAD_W-1:0] ang;
  logic [HEAD_W-1:0] idx_w;
  logic [6:0]        idx;
  logic              neg;
  logic [15:0]       raw;

  assign ang = (angle_i >= DEG_360) ? angle_i - DEG_360 : angle_i;

  // Fold to the first quadrant, keep the sign
  always_comb begin
    if (ang <= DEG_90) begin
      idx_w = ang;
      neg   = 1'b0;
    end else if (ang <= DEG_180) begin
      idx_w = DEG_180 - ang;
      neg   = 1'b0;
    end else if (ang <= DEG_270) begin
      idx_w = ang - DEG_180;
      neg   = 1'b1;
    end else begin
      idx_w = DEG_360 - ang;
      neg   = 1'b1;
    end
  end

  assign idx = idx_w[6:0];
  assign raw = sine_q15(idx);

  generate
    if (TRIG_FRAC_BITS >= 15) begin : g_up
      assign mag_o = (TRIG_FRAC_BITS+1)'({1'b0, raw} << (TRIG_FRAC_BITS - 15));
    end else begin : g_down
      localparam logic [16:0] HALF = 17'd1 << (14 - TRIG_FRAC_BITS);
      logic [16:0] rounded;
      assign rounded = ({1'b0, raw} + HALF) >> (15 - TRIG_FRAC_BITS);
      assign mag_o   = rounded[TRIG_FRAC_BITS:0];
    end
  endgenerate

  assign val_o = neg ? -$signed({1'b0, mag_o}) : $signed({1'b0, mag_o});

endmodule

@@ sv/mmd_lane.sv @@
// One wheel lane: drive level from speed, trig and turn, and the encoder
// target compare for the same wheel. Depends on mmd_pkg.
module mmd_lane #(
  parameter int COUNT_WIDTH    = mmd_pkg::COUNT_WIDTH_DEF,
  parameter int TRIG_FRAC_BITS = mmd_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic signed [mmd_pkg::SPEED_W-1:0]   speed_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]     trig_i,
  input  logic signed [mmd_pkg::TURN_W:0]      turn_i,
  input  logic signed [COUNT_WIDTH-1:0]        count_i,
  input  logic [mmd_pkg::TARGET_W-1:0]         target_i,
  output mmd_pkg::lane_res_t                   res_o
);
  import mmd_pkg::*;

  localparam int SUM_W = TRIG_FRAC_BITS + 11;
  localparam int CMP_W = (COUNT_WIDTH + 8 > TARGET_W) ? COUNT_WIDTH + 8 : TARGET_W;

  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-1:0]        sum_mag;
  logic [10:0]             whole;
  logic [6:0]              sat;
  logic [COUNT_WIDTH-1:0]  cnt_mag;
  logic [CMP_W-1:0]        cnt_scaled;

  assign sum     = speed_i * trig_i + (SUM_W'(turn_i) <<< TRIG_FRAC_BITS);
  assign sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  // Truncate toward zero on the magnitude, then clamp
  assign whole   = sum_mag[SUM_W-1:TRIG_FRAC_BITS];
  assign sat     = (whole > 11'(DRIVE_LIMIT)) ? DRIVE_LIMIT : whole[6:0];
  assign res_o.drive = sum[SUM_W-1] ? -$signed({1'b0, sat}) : $signed({1'b0, sat});

  assign cnt_mag    = count_i[COUNT_WIDTH-1] ? COUNT_WIDTH'(-count_i) : COUNT_WIDTH'(count_i);
  assign cnt_scaled = CMP_W'({cnt_mag, 8'd0});
  assign res_o.reached = cnt_scaled >= CMP_W'(target_i);

endmodule

@@ sv/mmd_div.sv @@
// Restoring divider, one quotient bit per cycle, for the tick target.
// Divides num * 2^TRIG_FRAC_BITS by the trig magnitude. Depends on mmd_pkg.
module mmd_div #(
  parameter int TRIG_FRAC_BITS = mmd_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [mmd_pkg::NUM_W-1:0]     num_i,
  input  logic [TRIG_FRAC_BITS:0]       den_i,
  output logic                          done_o,
  output logic [mmd_pkg::NUM_W+TRIG_FRAC_BITS-1:0] quo_o
);
  import mmd_pkg::*;

  localparam int DW    = NUM_W + TRIG_FRAC_BITS;
  localparam int CNT_W = $clog2(DW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DW-1:0]    shreg_q, shreg_d;
  logic [TRIG_FRAC_BITS:0]   rem_q, rem_d;
  logic [TRIG_FRAC_BITS:0]   den_q, den_d;
  logic [TRIG_FRAC_BITS+1:0] trial;
  logic                      ge;

  assign trial = {rem_q, shreg_q[DW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    shreg_d = shreg_q;
    rem_d   = rem_q;
    den_d   = den_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      shreg_d = {num_i, {TRIG_FRAC_BITS{1'b0}}};
      rem_d   = '0;
      den_d   = den_i;
    end else if (busy_q) begin
      shreg_d = {shreg_q[DW-2:0], ge};
      rem_d   = ge ? (TRIG_FRAC_BITS+1)'(trial - {1'b0, den_q})
                   : trial[TRIG_FRAC_BITS:0];
      cnt_d   = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    rem_q   <= rem_d;
    den_q   <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = shreg_q;

endmodule

@@ sv/mecanum_move_distance.sv @@
// Order: an encoder sample's result is registered in ST_CMP; a start command
// goes through ST_TRIG and ST_LANE to ST_DIV, where the bit-serial target
// divider walks 26 + TRIG_FRAC_BITS bits before the result is registered.
// Flow: one item in flight; ST_IDLE takes the next with the result slot free.
// Reset (rst_ni low, asynchronous): drives zero, no move, target zero,
// ticks_per_cm back to 9408, output channel empty.
module mecanum_move_distance #(
  parameter int COUNT_WIDTH    = mmd_pkg::COUNT_WIDTH_DEF,
  parameter int TRIG_FRAC_BITS = mmd_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // configuration: ticks_per_cm_q8
  input  logic                         cfg_wr_en_i,
  input  logic [mmd_pkg::TPC_W-1:0]    cfg_wr_data_i,
  // input stream
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // tdata, low bit up: speed[8], heading_deg[9], turn_rate[8], distance_cm[10],
  // front_left_count, front_right_count, back_left_count, back_right_count
  // [COUNT_WIDTH each], zero pad to bytes
  input  logic [((mmd_pkg::HDR_W + 4*COUNT_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  // tuser: mode (0 start, 1 encoder sample)
  input  logic                         s_axis_tuser_i,
  // output stream
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // tdata, low bit up: front_left_drive[8], front_right_drive[8],
  // back_left_drive[8], back_right_drive[8], moving, clear_encoders,
  // move_done, zero pad
  output logic [mmd_pkg::OUT_W-1:0]    m_axis_tdata_o
);
  import mmd_pkg::*;

  localparam int F     = TRIG_FRAC_BITS;
  localparam int DW    = NUM_W + F;
  localparam int CNT0  = HDR_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_TRIG,
    ST_LANE,
    ST_DIV
  } state_e;

  state_e state_q;

  logic                  in_acc;
  logic                  out_acc;
  logic                  out_valid_q;
  logic [OUT_W-1:0]      out_data_q;
  logic [TPC_W-1:0]      tpc_q;
  logic [TARGET_W-1:0]   target_q;
  logic                  active_q;
  logic signed [DRIVE_W-1:0] wheel_q [NUM_LANES];

  // latched command and sample fields
  logic signed [SPEED_W-1:0]   speed_q;
  logic [HEAD_W-1:0]           head_q;
  logic signed [TURN_W-1:0]    turn_q;
  logic [DIST_W-1:0]           dist_q;
  logic signed [COUNT_WIDTH-1:0] count_q [NUM_LANES];

  // trig stage
  logic [HEAD_W-1:0]     head_red;
  logic [F:0]            s45_mag, c45_mag, sh_mag, ch_mag;
  logic signed [F+1:0]   s45_val, c45_val, sh_val, ch_val;
  logic signed [F+1:0]   s45_q, c45_q;
  logic [F:0]            m_q;
  logic [F:0]            m_w;
  logic [NUM_W-1:0]      prod_q;

  // lanes
  logic signed [TURN_W:0]  turn_pos, turn_neg;
  logic signed [F+1:0]     lane_trig [NUM_LANES];
  logic signed [TURN_W:0]  lane_turn [NUM_LANES];
  lane_res_t               lane_res  [NUM_LANES];
  logic                    any_reached;

  // divider
  logic          div_start;
  logic          div_done;
  logic [DW-1:0] div_quo;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc         = out_valid_q && m_axis_tready_i;
  // Take a new transaction only with the result slot free or draining now
  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Heading modulo 360, then the four angles the kinematics need
  assign head_red = (head_q >= DEG_360) ? head_q - DEG_360 : head_q;

  mmd_trig #(.TRIG_FRAC_BITS(F)) u_trig_s45 (
    .angle_i(head_red + DEG_45),  .mag_o(s45_mag), .val_o(s45_val));
  mmd_trig #(.TRIG_FRAC_BITS(F)) u_trig_c45 (
    .angle_i(head_red + DEG_135), .mag_o(c45_mag), .val_o(c45_val));
  mmd_trig #(.TRIG_FRAC_BITS(F)) u_trig_sh (
    .angle_i(head_red),           .mag_o(sh_mag),  .val_o(sh_val));
  mmd_trig #(.TRIG_FRAC_BITS(F)) u_trig_ch (
    .angle_i(head_red + DEG_90),  .mag_o(ch_mag),  .val_o(ch_val));

  // Divisor is the larger of |sin h| and |cos h|; never below ~0.7, guard zero
  always_comb begin
    m_w = (sh_mag > ch_mag) ? sh_mag : ch_mag;
    if (m_w == '0) begin
      m_w = (F+1)'(1);
    end
  end

  // Left wheels add the turn, right wheels subtract it
  assign turn_pos = (TURN_W+1)'(turn_q);
  assign turn_neg = -turn_pos;

  assign lane_trig[0] = s45_q;  assign lane_turn[0] = turn_pos;  // front left
  assign lane_trig[1] = c45_q;  assign lane_turn[1] = turn_neg;  // front right
  assign lane_trig[2] = c45_q;  assign lane_turn[2] = turn_pos;  // back left
  assign lane_trig[3] = s45_q;  assign lane_turn[3] = turn_neg;  // back right

  generate
    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      mmd_lane #(
        .COUNT_WIDTH(COUNT_WIDTH),
        .TRIG_FRAC_BITS(F)
      ) u_lane (
        .speed_i (speed_q),
        .trig_i  (lane_trig[i]),
        .turn_i  (lane_turn[i]),
        .count_i (count_q[i]),
        .target_i(target_q),
        .res_o   (lane_res[i])
      );
    end
  endgenerate

  // Merge: any wheel at or past the target ends the move
  assign any_reached = lane_res[0].reached || lane_res[1].reached ||
                       lane_res[2].reached || lane_res[3].reached;

  assign div_start = (state_q == ST_LANE);

  mmd_div #(.TRIG_FRAC_BITS(F)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (prod_q),
    .den_i  (m_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Control state, move state and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      tpc_q       <= TICKS_PER_CM_RESET;
      target_q    <= '0;
      active_q    <= 1'b0;
      for (int i = 0; i < NUM_LANES; i++) begin
        wheel_q[i] <= '0;
      end
    end else begin
      if (cfg_wr_en_i) begin
        tpc_q <= cfg_wr_data_i;
      end
      if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= (s_axis_tuser_i == MODE_SAMPLE) ? ST_CMP : ST_TRIG;
          end
        end
        ST_CMP: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
          if (active_q && any_reached) begin
            // End of move: drop the drives, pulse done and clear
            active_q <= 1'b0;
            for (int i = 0; i < NUM_LANES; i++) begin
              wheel_q[i] <= '0;
            end
            out_data_q <= {(OUT_W - 35)'(0), 1'b1, 1'b1, 1'b0,
                           (NUM_LANES * DRIVE_W)'(0)};
          end else begin
            out_data_q <= {(OUT_W - 33)'(0), active_q,
                           wheel_q[3], wheel_q[2], wheel_q[1], wheel_q[0]};
          end
        end
        ST_TRIG: begin
          state_q <= ST_LANE;
        end
        ST_LANE: begin
          for (int i = 0; i < NUM_LANES; i++) begin
            wheel_q[i] <= lane_res[i].drive;
          end
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            target_q    <= div_quo[TARGET_W-1:0];
            active_q    <= 1'b1;
            out_valid_q <= 1'b1;
            out_data_q  <= {(OUT_W - 35)'(0), 1'b0, 1'b1, 1'b1,
                            wheel_q[3], wheel_q[2], wheel_q[1], wheel_q[0]};
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload: latch fields on acceptance, hold trig and divider operands
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      speed_q <= s_axis_tdata_i[SPEED_W-1:0];
      head_q  <= s_axis_tdata_i[SPEED_W +: HEAD_W];
      turn_q  <= s_axis_tdata_i[SPEED_W+HEAD_W +: TURN_W];
      dist_q  <= s_axis_tdata_i[SPEED_W+HEAD_W+TURN_W +: DIST_W];
      for (int i = 0; i < NUM_LANES; i++) begin
        count_q[i] <= s_axis_tdata_i[CNT0 + i*COUNT_WIDTH +: COUNT_WIDTH];
      end
    end
    if (state_q == ST_TRIG) begin
      s45_q  <= s45_val;
      c45_q  <= c45_val;
      m_q    <= m_w;
      prod_q <= NUM_W'(tpc_q) * NUM_W'(dist_q);
    end
  end

endmodule

@@ sv/mmd_checker.sv @@
// Port-level checks for mecanum_move_distance, attached by bind.
// Depends on mmd_pkg for the output layout.
module mmd_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid_i,
  input logic                      s_axis_tready_o,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [mmd_pkg::OUT_W-1:0] m_axis_tdata_o
);
  import mmd_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed or dropped");

  // A new transaction never finds a result still pending in the next cycle
  a_in_then_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !m_axis_tvalid_o)
    else $error("result slot busy right after input transaction");

  // Results come one per input: none right after one is taken
  a_no_back_to_back_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i |=> !m_axis_tvalid_o)
    else $error("result appeared without a new input");

  // The ending sample stops all wheels and requests a clear
  a_done_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[OUT_DONE_BIT] |->
      m_axis_tdata_o[OUT_CLEAR_BIT] && !m_axis_tdata_o[OUT_MOVING_BIT] &&
      (m_axis_tdata_o[31:0] == 32'd0))
    else $error("move done with wheels still driven");

endmodule

bind mecanum_move_distance mmd_checker u_mmd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);

@@ bench/mecanum_move_distance_tb.sv @@
// Self-checking bench for the mecanum move controller: stream driver and monitor,
// a per-item predictor of drives, tick target and done/clear flags.
// Depends on mmd_pkg and mecanum_move_distance only.
`timescale 1ns / 100ps

module mecanum_move_distance_tb;

  localparam int COUNT_W    = 24;
  localparam int FRAC_BITS  = 15;
  localparam int IN_W       = ((mmd_pkg::HDR_W + 4*COUNT_W + 7) / 8) * 8;
  localparam int PAD_W      = IN_W - mmd_pkg::HDR_W - 4*COUNT_W;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD  = 500;
  localparam int SETTLE     = 60;

  // One input transaction, fields as they travel on tdata plus the tuser mode
  typedef struct packed {
    logic                    mode;
    logic [3:0][COUNT_W-1:0] count;   // front_left is count[0]
    logic [9:0]              dist_cm;
    logic [7:0]              turn;
    logic [8:0]              heading;
    logic [7:0]              speed;
  } move_item_t;

  // One output transaction, laid out as the low 35 bits of m_axis_tdata_o
  typedef struct packed {
    logic            done;
    logic            clear;
    logic            moving;
    logic [3:0][7:0] drive;
  } motor_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [mmd_pkg::TPC_W-1:0] cfg_wr_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [mmd_pkg::OUT_W-1:0] m_axis_tdata;

  move_item_t cur_item = '0;
  move_item_t pending_items[$];
  motor_cmd_t motor_cmd_queue[$];

  int  src_idle_pct = 0;
  int  dst_stall_pct = 0;
  bit  long_hold_req = 1'b0;
  int  hold_count = 0;
  bit  in_taken = 1'b0;
  int  cycle_count = 0;
  int  mismatch_count = 0;
  int  items_queued = 0;
  logic [15:0] phase_tpc = mmd_pkg::TICKS_PER_CM_RESET;

  // Predictor state
  logic [15:0]     tpc_q8 = mmd_pkg::TICKS_PER_CM_RESET;
  logic [3:0][7:0] lane_level = '0;
  logic [31:0]     target_q8 = '0;
  bit              in_motion = 1'b0;

  // round(32768 * sin(d)), d = 0..90
  int quarter_sine [0:90] = '{
    0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126,
    5690, 6252, 6813, 7371, 7927, 8481, 9032, 9580, 10126, 10668,
    11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
    16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
    21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
    25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
    28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
    30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
    32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
    32768};

  string wheel_name [4] = '{"front_left", "front_right", "back_left", "back_right"};

  // Pack the fields without gaps, speed in the low bits, zero pad to bytes
  assign s_axis_tdata = {{PAD_W{1'b0}}, cur_item.count, cur_item.dist_cm, cur_item.turn,
                         cur_item.heading, cur_item.speed};

  mecanum_move_distance #(
    .COUNT_WIDTH   (COUNT_W),
    .TRIG_FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_wr_en_i    (cfg_wr_en),
    .cfg_wr_data_i  (cfg_wr_data),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (cur_item.mode),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Signed Q1.15 sine of a non-negative angle in degrees
  function automatic int sine_deg(int d);
    int r;
    r = d % 360;
    if (r <= 90) return quarter_sine[r];
    if (r <= 180) return quarter_sine[180 - r];
    if (r <= 270) return -quarter_sine[r - 180];
    return -quarter_sine[360 - r];
  endfunction

  // speed * trig + rotation, truncated toward zero, clamped to the drive limit
  function automatic logic [7:0] wheel_level(int spd, int trig, int rot);
    longint p, q;
    p = longint'(spd) * longint'(trig) + (longint'(rot) <<< FRAC_BITS);
    if (p < 0) q = -((-p) >>> FRAC_BITS);
    else q = p >>> FRAC_BITS;
    if (q > 100) q = 100;
    if (q < -100) q = -100;
    return q[7:0];
  endfunction

  // ticks_per_cm * distance / max(|sin|, |cos|), Q8 fraction, saturated to 32 bits
  function automatic logic [31:0] tick_target_q8(logic [15:0] tpc, logic [8:0] hdg,
                                                 logic [9:0] dist_cm);
    int h;
    longint sin_mag, cos_mag, m, t;
    h = int'(hdg) % 360;
    sin_mag = longint'(sine_deg(h));
    cos_mag = longint'(sine_deg(h + 90));
    if (sin_mag < 0) sin_mag = -sin_mag;
    if (cos_mag < 0) cos_mag = -cos_mag;
    m = (sin_mag > cos_mag) ? sin_mag : cos_mag;
    if (m == 0) m = 1;
    t = ((longint'(tpc) * longint'(dist_cm)) <<< FRAC_BITS) / m;
    if (t > 64'h0000_0000_FFFF_FFFF) t = 64'h0000_0000_FFFF_FFFF;
    return t[31:0];
  endfunction

  // Smallest encoder magnitude that ends a move with these parameters
  function automatic int ticks_to_reach(logic [15:0] tpc, logic [8:0] hdg,
                                        logic [9:0] dist_cm);
    longint t;
    t = longint'(tick_target_q8(tpc, hdg, dist_cm));
    return int'((t + 255) >>> 8);
  endfunction

  // Advance the predicted controller by one accepted item
  function automatic motor_cmd_t next_motor_cmd(move_item_t it);
    motor_cmd_t r;
    int spd, rot, h;
    longint mag;
    bit reached;
    r = '0;
    if (it.mode == mmd_pkg::MODE_START) begin
      spd = int'($signed(it.speed));
      rot = int'($signed(it.turn));
      h = int'(it.heading) % 360;
      lane_level[0] = wheel_level(spd, sine_deg(h + 45), rot);
      lane_level[1] = wheel_level(spd, sine_deg(h + 135), -rot);
      lane_level[2] = wheel_level(spd, sine_deg(h + 135), rot);
      lane_level[3] = wheel_level(spd, sine_deg(h + 45), -rot);
      target_q8 = tick_target_q8(tpc_q8, it.heading, it.dist_cm);
      in_motion = 1'b1;
      r.clear = 1'b1;
    end else if (in_motion) begin
      reached = 1'b0;
      for (int i = 0; i < 4; i++) begin
        mag = longint'($signed(it.count[i]));
        if (mag < 0) mag = -mag;
        if ((mag <<< 8) >= longint'(target_q8)) reached = 1'b1;
      end
      if (reached) begin
        lane_level = '0;
        in_motion = 1'b0;
        r.clear = 1'b1;
        r.done = 1'b1;
      end
    end
    r.drive = lane_level;
    r.moving = in_motion;
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample at the rising edge, check first, then record new input
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    motor_cmd_t want, got;
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      tpc_q8 = mmd_pkg::TICKS_PER_CM_RESET;
      lane_level = '0;
      target_q8 = '0;
      in_motion = 1'b0;
      in_taken <= 1'b0;
    end else begin
      if (cfg_wr_en) tpc_q8 = cfg_wr_data;
      // Check the output transaction before queueing this edge's input, since the
      // result leaving now belongs to an older item
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[34:0];
        if (motor_cmd_queue.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, actual %h", $time, got);
        end else begin
          want = motor_cmd_queue.pop_front();
          for (int i = 0; i < 4; i++)
            check_field({wheel_name[i], "_drive"}, int'($signed(want.drive[i])),
                        int'($signed(got.drive[i])));
          check_field("moving", int'(want.moving), int'(got.moving));
          check_field("clear_encoders", int'(want.clear), int'(got.clear));
          check_field("move_done", int'(want.done), int'(got.done));
        end
      end
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready)
        motor_cmd_queue.push_back(next_motor_cmd(cur_item));
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: change inputs at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (s_axis_tvalid && !in_taken) begin
      // hold the offered item until the block takes it
    end else if (rst_n && pending_items.size() != 0 &&
                 $urandom_range(99) >= src_idle_pct) begin
      cur_item <= pending_items.pop_front();
      s_axis_tvalid <= 1'b1;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here
  always @(negedge clk) begin
    if (long_hold_req && hold_count < LONG_HOLD) begin
      hold_count <= hold_count + 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= dst_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_start(int spd, int hdg, int turn, int dist_cm);
    move_item_t it;
    it.mode = mmd_pkg::MODE_START;
    it.speed = spd[7:0];
    it.heading = hdg[8:0];
    it.turn = turn[7:0];
    it.dist_cm = dist_cm[9:0];
    // counts are ignored on a start; keep them random
    for (int i = 0; i < 4; i++) it.count[i] = COUNT_W'($urandom());
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_sample(int c0, int c1, int c2, int c3);
    move_item_t it;
    it.mode = mmd_pkg::MODE_SAMPLE;
    it.speed = 8'($urandom());
    it.heading = 9'($urandom());
    it.turn = 8'($urandom());
    it.dist_cm = 10'($urandom());
    it.count[0] = c0[COUNT_W-1:0];
    it.count[1] = c1[COUNT_W-1:0];
    it.count[2] = c2[COUNT_W-1:0];
    it.count[3] = c3[COUNT_W-1:0];
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_noise();
    move_item_t it;
    it.mode = 1'($urandom_range(1));
    it.speed = 8'($urandom());
    it.heading = 9'($urandom());
    it.turn = 8'($urandom());
    it.dist_cm = 10'($urandom());
    for (int i = 0; i < 4; i++) it.count[i] = COUNT_W'($urandom());
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Random count below the stop threshold, boundary value now and then
  function automatic int count_below(int thr);
    int m;
    m = ($urandom_range(4) == 0) ? thr - 1 : $urandom_range(thr - 1);
    return $urandom_range(1) ? -m : m;
  endfunction

  // A well-formed move: start, a few samples short of the target, then usually
  // one sample that reaches it; otherwise the next start takes over
  task automatic push_move_run();
    int spd, turn, hdg, dist_cm, thr, lane, m;
    int c [4];
    spd = ($urandom_range(9) < 8) ? int'($urandom_range(200)) - 100 : int'($urandom_range(255));
    turn = ($urandom_range(9) < 8) ? int'($urandom_range(200)) - 100 : int'($urandom_range(255));
    hdg = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(359);
    case ($urandom_range(9))
      0:       dist_cm = 0;
      1, 2, 3: dist_cm = $urandom_range(1023);
      default: dist_cm = $urandom_range(60, 1);
    endcase
    push_start(spd, hdg, turn, dist_cm);
    thr = ticks_to_reach(phase_tpc, hdg[8:0], dist_cm[9:0]);
    if (thr > 0) begin
      repeat ($urandom_range(5)) begin
        foreach (c[i]) c[i] = count_below(thr);
        push_sample(c[0], c[1], c[2], c[3]);
      end
    end
    if ($urandom_range(99) < 85) begin
      foreach (c[i]) c[i] = (thr > 0) ? count_below(thr) : 0;
      lane = $urandom_range(3);
      m = thr + (($urandom_range(1) == 0) ? 0 : int'($urandom_range(1000)));
      if (m > 8388607) m = 8388607;
      c[lane] = $urandom_range(1) ? -m : m;
      push_sample(c[0], c[1], c[2], c[3]);
    end
  endtask

  task automatic fill_random(int n);
    int first;
    first = items_queued;
    while (items_queued - first < n) begin
      if ($urandom_range(99) < 80) push_move_run();
      else push_noise();
    end
  endtask

  // Let everything queued drain, then give the block time to go idle
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || s_axis_tvalid || motor_cmd_queue.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Only while idle: write ticks_per_cm and move on to new idle percentages
  task automatic begin_phase(logic [15:0] tpc, int src_pct, int dst_pct);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= tpc;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    phase_tpc = tpc;
    src_idle_pct = src_pct;
    dst_stall_pct = dst_pct;
  endtask

  task automatic push_directed();
    int thr;
    // samples while idle with extreme counts
    push_sample(8388607, -8388608, 0, -1);
    // largest speed, turn and distance: the left drives saturate
    push_start(127, 0, 127, 1023);
    thr = ticks_to_reach(phase_tpc, 9'd0, 10'd1023);
    push_sample(0, 0, 0, 0);
    push_sample(thr - 1, -(thr - 1), thr - 1, -(thr - 1));
    push_sample(0, -thr, 0, 0);
    push_sample(0, 0, 0, 0);
    // most negative fields, heading past 359, zero distance ends on first sample
    push_start(-128, 511, -128, 0);
    push_sample(0, 0, 0, 0);
    // a start during a move replaces it
    push_start(100, 45, 0, 10);
    push_start(100, 90, -100, 20);
    thr = ticks_to_reach(phase_tpc, 9'd90, 10'd20);
    push_sample(-(thr - 1), thr - 1, -(thr - 1), thr - 1);
    push_sample(0, 0, 0, thr);
    // the quadrant edges and wraparound headings
    push_start(-100, 135, 50, 5);
    push_start(50, 180, -50, 1);
    push_start(100, 270, 0, 1023);
    push_start(100, 359, 100, 7);
    push_start(1, 360, 1, 3);
    push_start(-1, 405, -1, 1);
    push_start(0, 225, 0, 2);
    push_start(100, 315, 100, 512);
    push_sample(8388607, 0, 0, 0);
    push_sample(-8388608, -8388608, -8388608, -8388608);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset value of ticks_per_cm, no idling, one long receiver hold-off
    push_directed();
    long_hold_req = 1'b1;
    fill_random(320);
    wait_drained();

    begin_phase(16'd0, 88, 0);
    fill_random(320);
    wait_drained();

    // Receiver stalls; the sender waits for every result halfway through
    begin_phase(16'hFFFF, 0, 88);
    fill_random(160);
    wait_drained();
    @(posedge clk);
    fill_random(160);
    wait_drained();

    begin_phase(16'($urandom_range(65534, 1)), 33, 33);
    fill_random(320);
    wait_drained();

    begin_phase(16'd1, 0, 0);
    fill_random(320);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
